// File: rtl/wfsb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfsb_pkg: shared types and constants
// Widths, request and status codes, and cell command types for the balancer.
// ----------------------------------------------------------------------------
package wfsb_pkg;
   localparam int MaxEntries = 256;
   localparam int IdxW       = $clog2(MaxEntries);
   localparam int CntW       = $clog2(MaxEntries + 1);
   localparam int TotW       = 20;
   localparam logic [TotW-1:0] TotalMax = '1;

   typedef enum logic [1:0] {
      REQ_REPORT = 2'd0,
      REQ_PICK   = 2'd1,
      REQ_ADMIT  = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_TAKEN    = 3'd0,
      ST_REJECTED = 3'd1,
      ST_DROPPED  = 3'd2,
      ST_PICKED   = 3'd3,
      ST_NONE     = 3'd4,
      ST_ADMITTED = 3'd5,
      ST_FULL     = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      CSR_CHECK_LIST = 2'd0,
      CSR_CODE_VER   = 2'd1,
      CSR_STALE      = 2'd2
   } csr_index_type;

   // one table entry as it moves between cells
   typedef struct packed {
      logic [31:0] addr;
      logic [11:0] free;
      logic [31:0] heard;
   } entry_type;

   // command broadcast from the controller to every cell
   typedef enum logic [2:0] {
      CMD_HOLD   = 3'd0,
      CMD_ROTATE = 3'd1, // every cell takes its right neighbor, last used cell takes head
      CMD_INSERT = 3'd2, // every cell takes its left neighbor, head takes the new entry
      CMD_WRITE  = 3'd3, // head cell takes the new entry only
      CMD_PATCH  = 3'd4  // rotate, last used cell takes the new entry instead of head
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      entry_type    data;
   } cell_cmd_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_REPORT, S_ADMIT, S_MOD, S_WALK, S_PURGE, S_DONE,
      S_FIX
   } state_type;
endpackage
`default_nettype wire

// File: rtl/wfsb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfsb channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface wfsb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] server_addr;
   logic [11:0] free_count;
   logic [7:0]  report_version;
   logic [15:0] code_version;
   logic [30:0] random_value;
   logic [31:0] now;
   modport source (output valid, req_type, server_addr, free_count, report_version,
                   code_version, random_value, now, input ready);
   modport sink (input valid, req_type, server_addr, free_count, report_version,
                 code_version, random_value, now, output ready);
endinterface

interface wfsb_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] chosen_addr;
   logic [19:0] free_total;
   modport source (output valid, status, chosen_addr, free_total, input ready);
   modport sink (input valid, status, chosen_addr, free_total, output ready);
endinterface

interface wfsb_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/wfsb_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfsb_cell: one table slot of the rotating entry ring
// Holds one entry; takes a neighbor's entry or the command's new entry.
// ----------------------------------------------------------------------------
module wfsb_cell (
   input  wire                    clock,
   input  wfsb_pkg::cell_cmd_type cmd,
   input  wire                    is_head,
   input  wfsb_pkg::entry_type    left,
   input  wfsb_pkg::entry_type    right,
   output wfsb_pkg::entry_type    value
);
   import wfsb_pkg::*;

   entry_type value_ff, value_in;

   always_comb begin
      value_in = value_ff;
      case (cmd.kind)
         CMD_ROTATE, CMD_PATCH: value_in = right;
         CMD_INSERT: value_in = is_head ? cmd.data : left;
         CMD_WRITE:  if (is_head) value_in = cmd.data;
         default:    value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule
`default_nettype wire

// File: rtl/wfsb_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfsb_chain: ring of entry cells
// Cell 0 is the head; on rotate each cell takes its right neighbor and the last
// used cell takes the head, so a rotation by the fill count walks every entry
// once in table order.
// ----------------------------------------------------------------------------
module wfsb_chain (
   input  wire                          clock,
   input  wfsb_pkg::cell_cmd_type       cmd,
   input  wire [wfsb_pkg::IdxW-1:0]     tail_idx,
   output wfsb_pkg::entry_type          head
);
   import wfsb_pkg::*;

   entry_type vals [MaxEntries];
   entry_type wrap;

   // entry that closes the ring: the head, or its replacement on a patch
   assign wrap = (cmd.kind == CMD_PATCH) ? cmd.data : vals[0];

   genvar g;
   generate
      for (g = 0; g < MaxEntries; g++) begin : g_cell
         wfsb_cell u_cell (
            .clock   (clock),
            .cmd     (cmd),
            .is_head (g == 0),
            .left    (vals[(g == 0) ? 0 : g - 1]),
            .right   ((IdxW'(g) == tail_idx) ? wrap : vals[(g + 1) % MaxEntries]),
            .value   (vals[g])
         );
      end
   endgenerate

   assign head = vals[0];
endmodule
`default_nettype wire

// File: rtl/wfsb_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfsb_divider: bit-serial remainder unit
// Computes dividend mod divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wfsb_divider (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [30:0]                   dividend,
   input  wire [wfsb_pkg::TotW-1:0]     divisor,
   output logic                         done,
   output logic [wfsb_pkg::TotW-1:0]    remainder
);
   import wfsb_pkg::*;

   logic [30:0]     quo_ff, quo_in;
   logic [TotW:0]   rem_ff, rem_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [TotW:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[TotW-1:0], quo_ff[30]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[29:0], 1'b0};
         rem_in = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd30) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = busy_ff && (cnt_ff == 5'd30);
   assign remainder = rem_in[TotW-1:0];
endmodule
`default_nettype wire

// File: rtl/weighted_free_slot_balancer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_free_slot_balancer_core
// Weighted random server selection over a ring of entry cells.
// ----------------------------------------------------------------------------
// Usage: requests (report, pick, admit) arrive on req_, one result per request
// leaves on rsp_. Registers are to be written on csr_ only while the block is
// idle; the block itself does not enforce this. The table lives in a ring
// of 256 cells kept in address order from the head; each report, admit and
// pick with a nonzero free total rotates the ring through its used entries,
// one per cycle. A pick runs the modulo unit and then the walk; a stale hit
// adds a purge rotation, a second modulo and a second walk. One request is
// handled at a time; req_ready is high only while idle, from the cycle after
// the result transfer. A result waits in the output register until taken; a
// stalled receiver holds the block. Reset empties the table and restores the
// register defaults (stale limit 20); there is no clearing pass.
// ----------------------------------------------------------------------------
module weighted_free_slot_balancer_core (
   input  wire        clock,
   input  wire        reset,
   wfsb_req_if.sink   req,
   wfsb_rsp_if.source rsp,
   wfsb_csr_if.sink   csr
);
   import wfsb_pkg::*;

   // configuration
   logic        check_ff;
   logic [15:0] cver_ff;
   logic [7:0]  stale_ff;

   // control
   state_type        state_ff, state_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [TotW-1:0]  total_ff, total_in;
   logic [CntW-1:0]  step_ff, step_in;
   logic [CntW-1:0]  pos_ff, pos_in;
   logic             found_ff, found_in;
   logic             posset_ff, posset_in;
   logic [20:0]      sum_ff, sum_in;
   logic [TotW:0]    choice_ff, choice_in;
   logic             hit_ff, hit_in;
   logic             stale_hit_ff, stale_hit_in;
   logic [2:0]       status_ff, status_in;
   logic [31:0]      chosen_ff, chosen_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // captured request
   logic [1:0]  q_type;
   logic [31:0] q_addr;
   logic [11:0] q_cnt;
   logic [7:0]  q_rver;
   logic [15:0] q_cver;
   logic [30:0] q_rnd;
   logic [31:0] q_now;

   cell_cmd_type cmd;
   entry_type    head, cleared, newent;
   logic         div_start, div_done;
   logic [TotW-1:0] div_rem;
   logic         req_fire, hd_stale;
   logic [31:0]  age;
   logic [IdxW-1:0] tail_idx;

   assign req_fire  = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign tail_idx  = (count_ff == '0) ? '0 : IdxW'(count_ff - CntW'(1));

   wfsb_chain u_chain (
      .clock    (clock),
      .cmd      (cmd),
      .tail_idx (tail_idx),
      .head     (head)
   );

   wfsb_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (q_rnd),
      .divisor   (total_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign age      = q_now - head.heard;
   assign hd_stale = (head.heard != '0) && (q_now > head.heard) &&
                     (age > {24'd0, stale_ff});

   always_comb begin
      cleared       = head;
      cleared.free  = '0;
      cleared.heard = '0;
   end

   function automatic logic [TotW-1:0] sub_sat(input logic [TotW-1:0] t,
                                               input logic [11:0] f);
      sub_sat = ({8'd0, f} > t) ? '0 : t - {8'd0, f};
   endfunction

   always_comb begin
      logic [TotW:0] add;
      logic          bad;
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      posset_in    = posset_ff;
      sum_in       = sum_ff;
      choice_in    = choice_ff;
      hit_in       = hit_ff;
      stale_hit_in = stale_hit_ff;
      status_in    = status_ff;
      chosen_in    = chosen_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.kind     = CMD_HOLD;
      cmd.data     = head;
      div_start    = 1'b0;
      add          = '0;
      bad          = (q_rver != 8'd1) ||
                     (q_cver != '0 && cver_ff != '0 && q_cver != cver_ff);
      newent.addr  = q_addr;
      newent.free  = '0;
      newent.heard = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               step_in   = '0;
               found_in  = 1'b0;
               posset_in = 1'b0;
               pos_in    = count_ff;
               case (req_kind_type'(req.req_type))
                  REQ_PICK: begin
                     state_in = S_DONE;
                     status_in = ST_NONE;
                     chosen_in = '0;
                     if (total_ff != '0) state_in = S_MOD;
                  end
                  REQ_REPORT, REQ_ADMIT: state_in = S_SCAN;
                  default: begin
                     status_in = ST_DROPPED;
                     chosen_in = '0;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         // one full rotation: find the address and the insert position
         S_SCAN: begin
            if (step_ff == count_ff) begin
               state_in = (q_type == REQ_ADMIT) ? S_ADMIT : S_REPORT;
               step_in  = '0;
            end else begin
               cmd.kind = CMD_ROTATE;
               step_in  = step_ff + CntW'(1);
               if (head.addr == q_addr) begin
                  found_in = 1'b1;
                  pos_in   = step_ff;
               end else if (!posset_ff && head.addr > q_addr && !found_ff) begin
                  posset_in = 1'b1;
                  pos_in    = step_ff;
               end
            end
         end
         // head is entry 0 again; bring the target to the head (or insert there)
         S_ADMIT, S_REPORT: begin
            chosen_in = '0;
            if (!found_ff && (count_ff == CntW'(MaxEntries) ||
                              (state_ff == S_REPORT && check_ff))) begin
               status_in = (state_ff == S_ADMIT) ? ST_FULL : ST_DROPPED;
               state_in  = S_DONE;
            end else if (step_ff != pos_ff) begin
               cmd.kind = CMD_ROTATE;
               step_in  = step_ff + CntW'(1);
            end else if (!found_ff) begin
               // insert at the head, then continue as if found
               cmd.kind = CMD_INSERT;
               cmd.data = newent;
               count_in = count_ff + CntW'(1);
               found_in = 1'b1;
               if (state_ff == S_ADMIT) begin
                  status_in = ST_ADMITTED;
                  state_in  = S_FIX;
               end
            end else if (state_ff == S_ADMIT) begin
               status_in = ST_ADMITTED;
               state_in  = S_FIX;
            end else begin
               total_in = sub_sat(total_ff, head.free);
               cmd.kind = CMD_WRITE;
               cmd.data = cleared;
               if (bad) begin
                  status_in = ST_REJECTED;
               end else begin
                  cmd.data.free  = q_cnt;
                  cmd.data.heard = q_now;
                  add = {1'b0, sub_sat(total_ff, head.free)} + {9'd0, q_cnt};
                  total_in = (add > {1'b0, TotalMax}) ? TotalMax : add[TotW-1:0];
                  status_in = ST_TAKEN;
               end
               state_in = S_FIX;
            end
         end
         // rotate the rest of the way so entry 0 is back at the head
         S_FIX: begin
            if (step_ff == count_ff || count_ff == '0) begin
               step_in  = '0;
               state_in = S_DONE;
            end else begin
               cmd.kind = CMD_ROTATE;
               step_in  = step_ff + CntW'(1);
            end
         end
         S_MOD: begin
            if (total_ff == '0) begin
               status_in = ST_NONE;
               state_in  = S_DONE;
            end else begin
               if (!div_done && step_ff == '0) begin
                  div_start = 1'b1;
                  step_in   = CntW'(1);
               end
               if (div_done) begin
                  choice_in    = {1'b0, div_rem} + 21'd1;
                  sum_in       = '0;
                  hit_in       = 1'b0;
                  stale_hit_in = 1'b0;
                  step_in      = '0;
                  state_in     = S_WALK;
               end
            end
         end
         // full rotation; at the first crossing take a slot or flag stale
         S_WALK: begin
            if (step_ff == count_ff) begin
               step_in = '0;
               if (stale_hit_ff) state_in = S_PURGE;
               else begin
                  if (!hit_ff) status_in = ST_NONE;
                  state_in = S_DONE;
               end
            end else begin
               cmd.kind = CMD_ROTATE;
               step_in  = step_ff + CntW'(1);
               sum_in   = sum_ff + {9'd0, head.free};
               if (!hit_ff && (sum_ff + {9'd0, head.free}) >= choice_ff) begin
                  hit_in = 1'b1;
                  if (hd_stale) stale_hit_in = 1'b1;
                  else begin
                     // the head leaves with one slot less
                     cmd.kind      = CMD_PATCH;
                     cmd.data      = head;
                     cmd.data.free = head.free - 12'd1;
                     total_in      = total_ff - TotW'(1);
                     chosen_in     = head.addr;
                     status_in     = ST_PICKED;
                  end
               end
            end
         end
         // full rotation clearing every stale entry, then retry
         S_PURGE: begin
            if (step_ff == count_ff) begin
               step_in  = '0;
               state_in = S_MOD;
            end else begin
               cmd.kind = CMD_ROTATE;
               step_in  = step_ff + CntW'(1);
               if (hd_stale) begin
                  cmd.kind = CMD_PATCH;
                  cmd.data = cleared;
                  total_in = sub_sat(total_ff, head.free);
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
            end else if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         check_ff     <= 1'b0;
         cver_ff      <= '0;
         stale_ff     <= 8'd20;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && csr.ready) begin
            case (csr_index_type'(csr.index))
               CSR_CHECK_LIST: check_ff <= csr.data[0];
               CSR_CODE_VER:   cver_ff  <= csr.data;
               CSR_STALE:      stale_ff <= csr.data[7:0];
               default:        ;
            endcase
         end
      end
      step_ff      <= step_in;
      pos_ff       <= pos_in;
      found_ff     <= found_in;
      posset_ff    <= posset_in;
      sum_ff       <= sum_in;
      choice_ff    <= choice_in;
      hit_ff       <= hit_in;
      stale_hit_ff <= stale_hit_in;
      status_ff    <= status_in;
      chosen_ff    <= chosen_in;
      if (req_fire) begin
         q_type <= req.req_type;
         q_addr <= req.server_addr;
         q_cnt  <= req.free_count;
         q_rver <= req.report_version;
         q_cver <= req.code_version;
         q_rnd  <= req.random_value;
         q_now  <= req.now;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.chosen_addr = (status_ff == ST_PICKED) ? chosen_ff : '0;
   assign rsp.free_total  = total_ff;

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxEntries)) else $error("entry count overflow");
   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !rsp_valid_ff) else $error("response outside done");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(status_ff))
      else $error("response dropped");
   a_pick_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_PICKED |-> rsp.chosen_addr == '0)
      else $error("address on non-pick");
`endif
endmodule
`default_nettype wire
